// ----- sv/vfpt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// vfpt_pkg
// Shared widths, register map and bundle types of the frustum point test.
// ---------------------------------------------------------------------------
package vfpt_pkg;

    localparam int COORD_W    = 24;
    localparam int DIR_W      = 16;
    localparam int DIST_W     = 23;
    localparam int CFG_W      = 24;
    localparam int CFG_IDX_W  = 3;

    localparam int DIR_FRAC_BITS_DEF = 14;

    localparam int DIFF_W     = COORD_W + 1;
    localparam int DPROD_W    = 2 * DIR_W;
    localparam int ZZ_W       = 2 * DIST_W;
    localparam int ZDD_W      = DIST_W + DPROD_W;
    localparam int HHS_W      = ZZ_W + DPROD_W;
    localparam int R1_W       = 2 * ZDD_W;
    localparam int R2_W       = ZZ_W + DPROD_W;

    localparam int K_W        = DIFF_W + DIR_W + 2;
    localparam int KMAG_W     = K_W - 2;
    localparam int QC_W       = DIFF_W + DIR_W + 1;
    localparam int QCMAG_W    = QC_W - 1;
    localparam int QW_W       = DIFF_W + DPROD_W + 3;
    localparam int QWMAG_W    = QW_W - 3;

    localparam int SQ_IN_W    = QWMAG_W;
    localparam int SQ_OUT_W   = 2 * SQ_IN_W;

    // input hold-off after a register write, while the derived constants settle
    localparam int DRV_LAT    = 10;

    localparam logic signed [COORD_W-1:0] CAMERA_RST = '0;
    localparam logic signed [DIR_W-1:0]   DIR_XY_RST = '0;
    localparam logic signed [DIR_W-1:0]   DIR_Z_RST  = 16'sd16384;
    localparam logic [DIST_W-1:0]         FAR_RST    = 23'd10240;
    localparam logic [DIST_W-1:0]         HALF_RST   = 23'd8145;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAMERA_X     = 3'd0,
        CFG_CAMERA_Y     = 3'd1,
        CFG_CAMERA_Z     = 3'd2,
        CFG_VIEW_DIR_X   = 3'd3,
        CFG_VIEW_DIR_Y   = 3'd4,
        CFG_VIEW_DIR_Z   = 3'd5,
        CFG_FAR_DISTANCE = 3'd6,
        CFG_HALF_EXTENT  = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] cam_x;
        logic signed [COORD_W-1:0] cam_y;
        logic signed [COORD_W-1:0] cam_z;
        logic signed [DIR_W-1:0]   dir_x;
        logic signed [DIR_W-1:0]   dir_y;
        logic signed [DIR_W-1:0]   dir_z;
        logic [DIST_W-1:0]         far_dist;
        logic [DIST_W-1:0]         half_ext;
    } cfg_t;

    typedef struct packed {
        logic signed [DPROD_W-1:0] dxdy;
        logic signed [DPROD_W-1:0] dydz;
        logic [DPROD_W-1:0]        s;
        logic [ZDD_W-1:0]          zdd;
        logic [HHS_W-1:0]          hhs;
        logic [R1_W-1:0]           r1;
        logic [R2_W-1:0]           r2;
        logic                      null_f;
    } drv_t;

    typedef struct packed {
        logic                valid;
        logic                kill;
        logic [KMAG_W-1:0]   kmag;
        logic [QCMAG_W-1:0]  qcmag;
        logic [QWMAG_W-1:0]  qwmag;
    } front_t;

    typedef struct packed {
        logic valid;
        logic kill;
    } side_t;

endpackage
`default_nettype wire

// ----- sv/vfpt_wmul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// vfpt_wmul
// Pipelined unsigned wide multiplier built from 32x32 limb products.
// One limb of b per step, two register layers per step.
// ---------------------------------------------------------------------------
module vfpt_wmul #(
    parameter int AW = 32,
    parameter int BW = 32,
    parameter int SW = 1
) (
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [AW-1:0]     a,
    input  wire logic [BW-1:0]     b,
    input  wire logic [SW-1:0]     side_in,
    output logic      [AW+BW-1:0]  p,
    output logic      [SW-1:0]     side_out
);
    localparam int LW  = 32;
    localparam int NA  = (AW + LW - 1) / LW;
    localparam int NB  = (BW + LW - 1) / LW;
    localparam int AP  = NA * LW;
    localparam int BP  = NB * LW;
    localparam int CW  = AP + BP;
    localparam int EOW = AP + LW;

    logic [AP-1:0] a_s [0:NB-1];
    logic [BP-1:0] b_s [0:NB-1];
    logic [CW-1:0] c_s [0:NB];
    logic [SW-1:0] d_s [0:NB];

    assign a_s[0] = AP'(a);
    assign b_s[0] = BP'(b);
    assign c_s[0] = '0;
    assign d_s[0] = side_in;

    for (genvar j = 0; j < NB; j++)
    begin : g_step
        logic [2*LW-1:0] pp_reg [NA];
        logic [CW-1:0]   c_reg;
        logic [SW-1:0]   d_reg;
        logic [CW-1:0]   c_out_reg;
        logic [SW-1:0]   d_out_reg;
        logic [EOW-1:0]  ev;
        logic [EOW-1:0]  od;
        logic [CW-1:0]   sum_next;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < NA; i++)
                begin
                    pp_reg[i] <= a_s[j][i*LW +: LW] * b_s[j][j*LW +: LW];
                end
                c_reg <= c_s[j];
                d_reg <= d_s[j];
            end
        end

        // even and odd limb products do not overlap: two concatenated rows
        always_comb
        begin
            ev = '0;
            od = '0;
            for (int i = 0; i < NA; i++)
            begin
                if (i % 2 == 0)
                begin
                    ev[i*LW +: 2*LW] = pp_reg[i];
                end
                else
                begin
                    od[i*LW +: 2*LW] = pp_reg[i];
                end
            end
        end

        assign sum_next = c_reg + (CW'(ev) << (j * LW)) + (CW'(od) << (j * LW));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                c_out_reg <= sum_next;
                d_out_reg <= d_reg;
            end
        end

        assign c_s[j+1] = c_out_reg;
        assign d_s[j+1] = d_out_reg;

        if (j < NB - 1)
        begin : g_fwd
            logic [AP-1:0] a_reg;
            logic [AP-1:0] a_out_reg;
            logic [BP-1:0] b_reg;
            logic [BP-1:0] b_out_reg;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    a_reg     <= a_s[j];
                    b_reg     <= b_s[j];
                    a_out_reg <= a_reg;
                    b_out_reg <= b_reg;
                end
            end

            assign a_s[j+1] = a_out_reg;
            assign b_s[j+1] = b_out_reg;
        end
    end

    assign p        = c_s[NB][AW+BW-1:0];
    assign side_out = d_s[NB];

endmodule
`default_nettype wire

// ----- sv/vfpt_derive.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// vfpt_derive
// Free-running pipeline that turns the camera registers into the plane
// coefficients and squared comparison constants.
// ---------------------------------------------------------------------------
module vfpt_derive (
    input  wire logic            clk,
    input  wire vfpt_pkg::cfg_t  cfg,
    output vfpt_pkg::drv_t       drv
);
    import vfpt_pkg::*;

    logic [DPROD_W-1:0]        dx2_reg;
    logic [DPROD_W-1:0]        dy2_reg;
    logic [DPROD_W-1:0]        dz2_reg;
    logic signed [DPROD_W-1:0] dxdy_reg;
    logic signed [DPROD_W-1:0] dydz_reg;
    logic [ZZ_W-1:0]           zz_reg;
    logic [ZZ_W-1:0]           hh_reg;
    logic [DIST_W-1:0]         z_reg;
    logic                      h_zero_reg;

    logic [DPROD_W-1:0]        s_reg;
    logic [DPROD_W-1:0]        dd_reg;
    logic signed [DPROD_W-1:0] dxdy2_reg;
    logic signed [DPROD_W-1:0] dydz2_reg;
    logic [ZZ_W-1:0]           zz2_reg;
    logic [ZZ_W-1:0]           hh2_reg;
    logic [DIST_W-1:0]         z2_reg;
    logic                      null_reg;

    logic [DPROD_W-1:0]        s_next;
    logic [ZDD_W-1:0]          zdd;
    logic [HHS_W-1:0]          hhs;
    logic [R1_W-1:0]           r1;
    logic [R2_W-1:0]           r2;

    always_ff @(posedge clk)
    begin
        dx2_reg    <= DPROD_W'(cfg.dir_x * cfg.dir_x);
        dy2_reg    <= DPROD_W'(cfg.dir_y * cfg.dir_y);
        dz2_reg    <= DPROD_W'(cfg.dir_z * cfg.dir_z);
        dxdy_reg   <= cfg.dir_x * cfg.dir_y;
        dydz_reg   <= cfg.dir_y * cfg.dir_z;
        zz_reg     <= cfg.far_dist * cfg.far_dist;
        hh_reg     <= cfg.half_ext * cfg.half_ext;
        z_reg      <= cfg.far_dist;
        h_zero_reg <= (cfg.half_ext == '0);
    end

    assign s_next = dx2_reg + dz2_reg;

    always_ff @(posedge clk)
    begin
        s_reg     <= s_next;
        dd_reg    <= s_next + dy2_reg;
        dxdy2_reg <= -dxdy_reg;
        dydz2_reg <= -dydz_reg;
        zz2_reg   <= zz_reg;
        hh2_reg   <= hh_reg;
        z2_reg    <= z_reg;
        // direction along world up, or a point-sized far plane: no culling
        null_reg  <= h_zero_reg || (s_next == '0);
    end

    vfpt_wmul #(.AW(DIST_W), .BW(DPROD_W), .SW(1)) u_zdd (
        .clk      (clk),
        .en       (1'b1),
        .a        (z2_reg),
        .b        (dd_reg),
        .side_in  (1'b0),
        .p        (zdd),
        .side_out ()
    );

    vfpt_wmul #(.AW(ZZ_W), .BW(DPROD_W), .SW(1)) u_r2 (
        .clk      (clk),
        .en       (1'b1),
        .a        (zz2_reg),
        .b        (dd_reg),
        .side_in  (1'b0),
        .p        (r2),
        .side_out ()
    );

    vfpt_wmul #(.AW(ZZ_W), .BW(DPROD_W), .SW(1)) u_hhs (
        .clk      (clk),
        .en       (1'b1),
        .a        (hh2_reg),
        .b        (s_reg),
        .side_in  (1'b0),
        .p        (hhs),
        .side_out ()
    );

    vfpt_wmul #(.AW(ZDD_W), .BW(ZDD_W), .SW(1)) u_r1 (
        .clk      (clk),
        .en       (1'b1),
        .a        (zdd),
        .b        (zdd),
        .side_in  (1'b0),
        .p        (r1),
        .side_out ()
    );

    // coefficients of the up-plane normal W are stored negated: -dx*dy, -dy*dz
    assign drv.dxdy   = dxdy2_reg;
    assign drv.dydz   = dydz2_reg;
    assign drv.s      = s_reg;
    assign drv.zdd    = zdd;
    assign drv.hhs    = hhs;
    assign drv.r1     = r1;
    assign drv.r2     = r2;
    assign drv.null_f = null_reg;

endmodule
`default_nettype wire

// ----- sv/vfpt_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// vfpt_front
// Four-stage front end: offset from the apex, plane dot products, the far
// plane test and magnitudes for the squared side-plane tests.
// ---------------------------------------------------------------------------
module vfpt_front #(
    parameter int DIR_FRAC_BITS = vfpt_pkg::DIR_FRAC_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 en,
    input  wire logic                                 in_beat,
    input  wire logic signed [vfpt_pkg::COORD_W-1:0]  point_x,
    input  wire logic signed [vfpt_pkg::COORD_W-1:0]  point_y,
    input  wire logic signed [vfpt_pkg::COORD_W-1:0]  point_z,
    input  wire vfpt_pkg::cfg_t                       cfg,
    input  wire vfpt_pkg::drv_t                       drv,
    output vfpt_pkg::front_t                          fr
);
    import vfpt_pkg::*;

    localparam int KS_W = K_W + DIR_FRAC_BITS;

    logic                         valid0_reg;
    logic                         valid1_reg;
    logic                         valid2_reg;
    logic                         valid3_reg;

    logic signed [DIFF_W-1:0]     qx_reg;
    logic signed [DIFF_W-1:0]     qy_reg;
    logic signed [DIFF_W-1:0]     qz_reg;

    logic signed [DIFF_W+DIR_W-1:0]     kx_reg;
    logic signed [DIFF_W+DIR_W-1:0]     ky_reg;
    logic signed [DIFF_W+DIR_W-1:0]     kz_reg;
    logic signed [DIFF_W+DIR_W-1:0]     cx_reg;
    logic signed [DIFF_W+DIR_W-1:0]     cz_reg;
    logic signed [DIFF_W+DPROD_W-1:0]   wx_reg;
    logic signed [DIFF_W+DPROD_W:0]     wy_reg;
    logic signed [DIFF_W+DPROD_W-1:0]   wz_reg;

    logic signed [K_W-1:0]        k_reg;
    logic signed [QC_W-1:0]       qc_reg;
    logic signed [QW_W-1:0]       qw_reg;

    logic                         kill_reg;
    logic [KMAG_W-1:0]            kmag_reg;
    logic [QCMAG_W-1:0]           qcmag_reg;
    logic [QWMAG_W-1:0]           qwmag_reg;

    logic [KS_W-1:0]              kshift;
    logic signed [QC_W-1:0]       qc_abs;
    logic signed [QW_W-1:0]       qw_abs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid0_reg <= 1'b0;
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end
        else if (en)
        begin
            valid0_reg <= in_beat;
            valid1_reg <= valid0_reg;
            valid2_reg <= valid1_reg;
            valid3_reg <= valid2_reg;
        end
    end

    assign kshift = {k_reg, {DIR_FRAC_BITS{1'b0}}};
    assign qc_abs = qc_reg[QC_W-1] ? -qc_reg : qc_reg;
    assign qw_abs = qw_reg[QW_W-1] ? -qw_reg : qw_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qx_reg <= DIFF_W'(point_x) - DIFF_W'(cfg.cam_x);
            qy_reg <= DIFF_W'(point_y) - DIFF_W'(cfg.cam_y);
            qz_reg <= DIFF_W'(point_z) - DIFF_W'(cfg.cam_z);

            kx_reg <= qx_reg * cfg.dir_x;
            ky_reg <= qy_reg * cfg.dir_y;
            kz_reg <= qz_reg * cfg.dir_z;
            cx_reg <= qz_reg * cfg.dir_x;
            cz_reg <= qx_reg * cfg.dir_z;
            wx_reg <= qx_reg * drv.dxdy;
            wy_reg <= qy_reg * $signed({1'b0, drv.s});
            wz_reg <= qz_reg * drv.dydz;

            k_reg  <= K_W'(kx_reg) + K_W'(ky_reg) + K_W'(kz_reg);
            qc_reg <= QC_W'(cx_reg) - QC_W'(cz_reg);
            qw_reg <= QW_W'(wx_reg) + QW_W'(wy_reg) + QW_W'(wz_reg);

            // behind the camera or beyond the far plane
            kill_reg  <= k_reg[K_W-1] || (kshift > KS_W'(drv.zdd));
            kmag_reg  <= k_reg[KMAG_W-1:0];
            qcmag_reg <= qc_abs[QCMAG_W-1:0];
            qwmag_reg <= qw_abs[QWMAG_W-1:0];
        end
    end

    assign fr.valid = valid3_reg;
    assign fr.kill  = kill_reg;
    assign fr.kmag  = kmag_reg;
    assign fr.qcmag = qcmag_reg;
    assign fr.qwmag = qwmag_reg;

endmodule
`default_nettype wire

// ----- sv/view_frustum_point_test_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// One point per cycle while the output is not stalled and no settle is pending.
// The stall-all pipeline has 4 front stages, 4 for the squares, 8 for the
// limb-serial wide products and an output register.
// After reset and after every register write the input stalls while the
// derived plane constants settle.
// Reset is asynchronous, active low; it clears valid bits and loads the camera registers with their reset values.
// ---------------------------------------------------------------------------
// view_frustum_point_test_unit
// Streams points through exact integer sign tests against the far plane
// and the four side planes of one camera frustum.
// ---------------------------------------------------------------------------
module view_frustum_point_test_unit #(
    parameter int DIR_FRAC_BITS = vfpt_pkg::DIR_FRAC_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [vfpt_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [vfpt_pkg::CFG_W-1:0]            cfg_data,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic signed [vfpt_pkg::COORD_W-1:0]   point_x,
    input  wire logic signed [vfpt_pkg::COORD_W-1:0]   point_y,
    input  wire logic signed [vfpt_pkg::COORD_W-1:0]   point_z,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic                                       inside_res
);
    import vfpt_pkg::*;

    localparam int CNT_W  = $clog2(DRV_LAT + 1);
    localparam int CMP_W  = R1_W + SQ_OUT_W + 2 * DIR_FRAC_BITS;
    localparam int LHS0_W = HHS_W + SQ_OUT_W;
    localparam int RHS1_W = R1_W + SQ_OUT_W;
    localparam int RHS2_W = R2_W + SQ_OUT_W;

    cfg_t              cfg_reg;
    logic [CNT_W-1:0]  settle_cnt_reg;
    logic              out_valid_reg;
    logic              inside_reg;
    logic              adv;
    logic              in_beat;

    drv_t              drv;
    front_t            fr;
    side_t             sq_side;
    side_t             pr_side;

    logic [SQ_OUT_W-1:0] kk;
    logic [SQ_OUT_W-1:0] cc;
    logic [SQ_OUT_W-1:0] ww;
    logic [LHS0_W-1:0]   lhs0;
    logic [RHS1_W-1:0]   rhs1;
    logic [RHS2_W-1:0]   rhs2;
    logic [CMP_W-1:0]    lhs;
    logic                inside_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cam_x    <= CAMERA_RST;
            cfg_reg.cam_y    <= CAMERA_RST;
            cfg_reg.cam_z    <= CAMERA_RST;
            cfg_reg.dir_x    <= DIR_XY_RST;
            cfg_reg.dir_y    <= DIR_XY_RST;
            cfg_reg.dir_z    <= DIR_Z_RST;
            cfg_reg.far_dist <= FAR_RST;
            cfg_reg.half_ext <= HALF_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_CAMERA_X:     cfg_reg.cam_x    <= $signed(cfg_data);
                CFG_CAMERA_Y:     cfg_reg.cam_y    <= $signed(cfg_data);
                CFG_CAMERA_Z:     cfg_reg.cam_z    <= $signed(cfg_data);
                CFG_VIEW_DIR_X:   cfg_reg.dir_x    <= $signed(cfg_data[DIR_W-1:0]);
                CFG_VIEW_DIR_Y:   cfg_reg.dir_y    <= $signed(cfg_data[DIR_W-1:0]);
                CFG_VIEW_DIR_Z:   cfg_reg.dir_z    <= $signed(cfg_data[DIR_W-1:0]);
                CFG_FAR_DISTANCE: cfg_reg.far_dist <= cfg_data[DIST_W-1:0];
                CFG_HALF_EXTENT:  cfg_reg.half_ext <= cfg_data[DIST_W-1:0];
                default:          cfg_reg          <= cfg_reg;
            endcase
        end
    end

    // hold off input until the derived constants reflect the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_cnt_reg <= CNT_W'(DRV_LAT);
        end
        else if (cfg_we)
        begin
            settle_cnt_reg <= CNT_W'(DRV_LAT);
        end
        else if (settle_cnt_reg != '0)
        begin
            settle_cnt_reg <= settle_cnt_reg - 1'b1;
        end
    end

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv || (settle_cnt_reg != '0);
    assign in_beat  = in_valid && !in_stall;

    vfpt_derive u_derive (
        .clk (clk),
        .cfg (cfg_reg),
        .drv (drv)
    );

    vfpt_front #(.DIR_FRAC_BITS(DIR_FRAC_BITS)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_beat (in_beat),
        .point_x (point_x),
        .point_y (point_y),
        .point_z (point_z),
        .cfg     (cfg_reg),
        .drv     (drv),
        .fr      (fr)
    );

    vfpt_wmul #(.AW(SQ_IN_W), .BW(SQ_IN_W), .SW($bits(side_t))) u_sq_k (
        .clk      (clk),
        .en       (adv),
        .a        (SQ_IN_W'(fr.kmag)),
        .b        (SQ_IN_W'(fr.kmag)),
        .side_in  ({fr.valid, fr.kill}),
        .p        (kk),
        .side_out (sq_side)
    );

    vfpt_wmul #(.AW(SQ_IN_W), .BW(SQ_IN_W), .SW(1)) u_sq_c (
        .clk      (clk),
        .en       (adv),
        .a        (SQ_IN_W'(fr.qcmag)),
        .b        (SQ_IN_W'(fr.qcmag)),
        .side_in  (1'b0),
        .p        (cc),
        .side_out ()
    );

    vfpt_wmul #(.AW(SQ_IN_W), .BW(SQ_IN_W), .SW(1)) u_sq_w (
        .clk      (clk),
        .en       (adv),
        .a        (fr.qwmag),
        .b        (fr.qwmag),
        .side_in  (1'b0),
        .p        (ww),
        .side_out ()
    );

    vfpt_wmul #(.AW(HHS_W), .BW(SQ_OUT_W), .SW($bits(side_t))) u_lhs (
        .clk      (clk),
        .en       (adv),
        .a        (drv.hhs),
        .b        (kk),
        .side_in  (sq_side),
        .p        (lhs0),
        .side_out (pr_side)
    );

    vfpt_wmul #(.AW(R1_W), .BW(SQ_OUT_W), .SW(1)) u_rhs1 (
        .clk      (clk),
        .en       (adv),
        .a        (drv.r1),
        .b        (cc),
        .side_in  (1'b0),
        .p        (rhs1),
        .side_out ()
    );

    vfpt_wmul #(.AW(R2_W), .BW(SQ_OUT_W), .SW(1)) u_rhs2 (
        .clk      (clk),
        .en       (adv),
        .a        (drv.r2),
        .b        (ww),
        .side_in  (1'b0),
        .p        (rhs2),
        .side_out ()
    );

    // H^2 S K^2 scaled by 2^(2B) against the squared side-plane terms
    assign lhs = CMP_W'({lhs0, {(2 * DIR_FRAC_BITS){1'b0}}});
    assign inside_next = drv.null_f
                      || (!pr_side.kill && (lhs >= CMP_W'(rhs1)) && (lhs >= CMP_W'(rhs2)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= pr_side.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            inside_reg <= inside_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign inside_res = inside_reg;

    a_cfg_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> in_stall)
        else $error("input taken right after a register write");

    a_beat_moves_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> adv)
        else $error("input beat taken while the pipeline is frozen");

    a_settle_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (settle_cnt_reg != '0 && !cfg_we) |=>
            (settle_cnt_reg == $past(settle_cnt_reg) - 1'b1))
        else $error("settle counter did not count down");

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Streams points through the frustum point test unit under several camera
// set-ups and compares every inside flag with an exact integer prediction.
// ---------------------------------------------------------------------------
module tb_top;
    import vfpt_pkg::*;

    class frustum_board;
        logic [CFG_W-1:0] regs [8];
        bit               inside_q [$];
        int               errors;
        int               reported;

        function new();
            regs[CFG_CAMERA_X]     = CFG_W'(CAMERA_RST);
            regs[CFG_CAMERA_Y]     = CFG_W'(CAMERA_RST);
            regs[CFG_CAMERA_Z]     = CFG_W'(CAMERA_RST);
            regs[CFG_VIEW_DIR_X]   = CFG_W'(DIR_XY_RST);
            regs[CFG_VIEW_DIR_Y]   = CFG_W'(DIR_XY_RST);
            regs[CFG_VIEW_DIR_Z]   = CFG_W'(DIR_Z_RST);
            regs[CFG_FAR_DISTANCE] = CFG_W'(FAR_RST);
            regs[CFG_HALF_EXTENT]  = CFG_W'(HALF_RST);
            errors = 0;
            reported = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] v);
            regs[idx] = v;
        endfunction

        function void fail_note(string what, bit exp_v, bit got_v);
            errors++;
            if (reported < 10)
            begin
                reported++;
                $display("%0t: %s expected %0d actual %0d", $time, what, exp_v, got_v);
            end
        endfunction

        // exact sign tests: far plane, then the side pairs squared
        function bit inside_of(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                               logic [COORD_W-1:0] pz);
            longint dx, dy, dz, z, h, s, dd, zdd, qx, qy, qz, k, qc, qw;
            logic [255:0] lhs, rhs, mc, mw;
            dx = longint'($signed(regs[CFG_VIEW_DIR_X][DIR_W-1:0]));
            dy = longint'($signed(regs[CFG_VIEW_DIR_Y][DIR_W-1:0]));
            dz = longint'($signed(regs[CFG_VIEW_DIR_Z][DIR_W-1:0]));
            z  = longint'(regs[CFG_FAR_DISTANCE][DIST_W-1:0]);
            h  = longint'(regs[CFG_HALF_EXTENT][DIST_W-1:0]);
            s  = dx * dx + dz * dz;
            dd = s + dy * dy;
            zdd = z * dd;
            if (h == 0 || s == 0)
                return 1'b1;
            qx = longint'($signed(px)) - longint'($signed(regs[CFG_CAMERA_X]));
            qy = longint'($signed(py)) - longint'($signed(regs[CFG_CAMERA_Y]));
            qz = longint'($signed(pz)) - longint'($signed(regs[CFG_CAMERA_Z]));
            k  = qx * dx + qy * dy + qz * dz;
            qc = -qx * dz + qz * dx;
            qw = -qx * dx * dy + qy * s - qz * dy * dz;
            if (k < 0 || k * (longint'(1) << DIR_FRAC_BITS_DEF) > zdd)
                return 1'b0;
            mc = 256'(qc < 0 ? -qc : qc);
            mw = 256'(qw < 0 ? -qw : qw);
            lhs = (256'(h) * 256'(h) * 256'(k) * 256'(k) * 256'(s))
                  << (2 * DIR_FRAC_BITS_DEF);
            rhs = 256'(zdd) * 256'(zdd) * mc * mc;
            if (lhs < rhs)
                return 1'b0;
            rhs = 256'(z) * 256'(z) * 256'(dd) * mw * mw;
            return lhs >= rhs;
        endfunction

        function void note_point(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                                 logic [COORD_W-1:0] pz);
            inside_q.push_back(inside_of(px, py, pz));
        endfunction

        function void check_result(bit got);
            bit exp_v;
            if (inside_q.size() == 0)
                fail_note("result beat with nothing pending:", 1'b0, got);
            else
            begin
                exp_v = inside_q.pop_front();
                if (exp_v != got)
                    fail_note("inside_res mismatch:", exp_v, got);
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_W-1:0]          cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    logic signed [COORD_W-1:0] point_x, point_y, point_z;
    logic                      out_valid;
    logic                      out_stall;
    logic                      inside_res;

    frustum_board board;
    int  tx_idle_pct;
    int  rx_idle_pct;
    bit  rx_hold;

    view_frustum_point_test_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .inside_res (inside_res)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    always @(negedge clk)
        out_stall <= rx_hold || ($urandom_range(99) < rx_idle_pct);

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            board.check_result(inside_res);

    task automatic send_point(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                              logic [COORD_W-1:0] pz);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        point_x = px;
        point_y = py;
        point_z = pz;
        do
            @(posedge clk);
        while (in_stall);
        board.note_point(px, py, pz);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (board.inside_q.size() != 0)
            @(posedge clk);
        repeat (DRV_LAT + 20) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] v);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = v;
        board.set_reg(idx, v);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_camera(longint cx, longint cy, longint cz, longint dx, longint dy,
                              longint dz, longint far_d, longint half_e);
        write_reg(CFG_CAMERA_X, CFG_W'(cx));
        write_reg(CFG_CAMERA_Y, CFG_W'(cy));
        write_reg(CFG_CAMERA_Z, CFG_W'(cz));
        write_reg(CFG_VIEW_DIR_X, CFG_W'(dx));
        write_reg(CFG_VIEW_DIR_Y, CFG_W'(dy));
        write_reg(CFG_VIEW_DIR_Z, CFG_W'(dz));
        write_reg(CFG_FAR_DISTANCE, CFG_W'(far_d));
        write_reg(CFG_HALF_EXTENT, CFG_W'(half_e));
    endtask

    // mostly points spread around the frustum volume, some pure noise
    task automatic random_point();
        longint cx, cy, cz, dx, dy, dz, t, h;
        if ($urandom_range(99) < 20)
            send_point(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
        else
        begin
            cx = longint'($signed(board.regs[CFG_CAMERA_X]));
            cy = longint'($signed(board.regs[CFG_CAMERA_Y]));
            cz = longint'($signed(board.regs[CFG_CAMERA_Z]));
            dx = longint'($signed(board.regs[CFG_VIEW_DIR_X][DIR_W-1:0]));
            dy = longint'($signed(board.regs[CFG_VIEW_DIR_Y][DIR_W-1:0]));
            dz = longint'($signed(board.regs[CFG_VIEW_DIR_Z][DIR_W-1:0]));
            h  = longint'(board.regs[CFG_HALF_EXTENT][DIST_W-1:0]);
            t  = $urandom_range(0, board.regs[CFG_FAR_DISTANCE][DIST_W-1:0] * 5 / 4);
            h  = h + 1;
            send_point(COORD_W'(cx + ((dx * t) >>> 14) + $signed($urandom % (2 * h)) - h),
                       COORD_W'(cy + ((dy * t) >>> 14) + $signed($urandom % (2 * h)) - h),
                       COORD_W'(cz + ((dz * t) >>> 14) + $signed($urandom % (2 * h)) - h));
        end
    endtask

    task automatic random_camera();
        longint far_d;
        far_d = ($urandom_range(9) == 0) ? 8388607 : $urandom_range(1, 1 << 16);
        set_camera($signed(24'($urandom)) >>> $urandom_range(0, 12),
                   $signed(24'($urandom)) >>> $urandom_range(0, 12),
                   $signed(24'($urandom)) >>> $urandom_range(0, 12),
                   $signed(16'($urandom)), $signed(16'($urandom)), $signed(16'($urandom)),
                   far_d, $urandom_range(0, far_d < 4194303 ? 2 * far_d : 8388607));
    endtask

    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        board = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        point_x = '0;
        point_y = '0;
        point_z = '0;
        rx_hold = 1'b0;
        tx_idle_pct = 38;
        rx_idle_pct = 70;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset camera: field extremes, on-axis, beyond the far plane, behind
        send_point(24'h800000, 24'h800000, 24'h800000);
        send_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        send_point(24'h000000, 24'h000000, 24'h000000);
        send_point(24'h000000, 24'h000000, 24'd5000);
        send_point(24'h000000, 24'h000000, 24'd10240);
        send_point(24'h000000, 24'h000000, 24'd10241);
        send_point(24'd8145, 24'd8145, 24'd10240);
        send_point(24'd8146, 24'h000000, 24'd10240);
        send_point(24'h000000, -24'sd8146, 24'd10240);
        send_point(24'h000000, 24'h000000, -24'sd1);
        send_point(24'h7FFFFF, 24'h800000, 24'h000100);
        for (int i = 0; i < 60; i++)
            random_point();
        drain();

        for (int ph = 1; ph < 11; ph++)
        begin
            if (ph == 4)
            begin
                tx_idle_pct = 70;
                rx_idle_pct = 38;
            end
            else if (ph == 7)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case (ph)
                1: set_camera(8388607, 8388607, 8388607, 32767, 32767, 32767,
                              8388607, 8388607);
                2: set_camera(-8388608, -8388608, -8388608, -32768, -32768, -32768,
                              1, 0);
                3: set_camera(100, -200, 300, 0, 16384, 0, 10240, 8145);
                4: set_camera(0, 0, 0, 0, 0, 0, 10240, 8145);
                5: set_camera(-5000, 700, 20, -32768, 0, 9000, 20000, 0);
                default: random_camera();
            endcase
            if (ph == 2)
            begin
                send_point(24'h800000, 24'h800000, 24'h800000);
                send_point(24'h7FFFFF, 24'h800000, 24'h800000);
            end
            if (ph == 6)
            begin
                // receiver holds off long enough for the pipe to back up
                fork
                    begin
                        rx_hold = 1'b1;
                        repeat (200) @(posedge clk);
                        rx_hold = 1'b0;
                    end
                    for (int i = 0; i < 40; i++)
                        random_point();
                join
            end
            for (int i = 0; i < 70; i++)
            begin
                random_point();
                if (ph == 8 && i == 30)
                begin
                    @(negedge clk);
                    in_valid = 1'b0;
                    while (board.inside_q.size() != 0)
                        @(posedge clk);
                end
            end
            drain();
        end

        if (board.errors == 0 && board.inside_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// ----- view_frustum_point_test_unit.f -----
sv/vfpt_pkg.sv
sv/vfpt_wmul.sv
sv/vfpt_derive.sv
sv/vfpt_front.sv
sv/view_frustum_point_test_unit.sv
dv/tb_top.sv
